[rtl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

    localparam int RAW_W   = 20;
    localparam int TEMP_W  = 15;
    localparam int PRESS_W = 25;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 31;
    localparam int CFG_IDX_W = 8;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;
    localparam logic [PRESS_W-1:0]       PRESS_MAX = 25'h1FFFFFF;
    localparam logic signed [25:0]       FINE_OFS = 26'sd128000;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_A = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_B = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_C = 8'd3;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    typedef struct packed {
        logic [NUM_W-1:0]         num_mag;
        logic [DEN_W-1:0]         den_mag;
        logic                     neg;
        logic                     nz;
        logic signed [TEMP_W-1:0] temp;
    } div_in_t;

    typedef struct packed {
        logic [NUM_W-1:0]         quot;
        logic                     neg;
        logic                     nz;
        logic signed [TEMP_W-1:0] temp;
    } div_out_t;

endpackage

`default_nettype wire

[rtl/bsc_front.sv]
// ----------------------------------------------------------------------------
// bsc_front
// Temperature compensation and pressure numerator/divisor, eleven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [bsc_pkg::RAW_W-1:0]       raw_temp,
    input  wire logic [bsc_pkg::RAW_W-1:0]       raw_press,
    input  wire bsc_pkg::cal_t                   cal,
    output logic                                 out_valid,
    output bsc_pkg::div_in_t                     out
);

    localparam int NST = 11;

    logic [NST-1:0] vld_reg;

    logic signed [17:0] d1_reg;
    logic signed [16:0] d2_reg;
    logic signed [33:0] m1_reg, sq2_reg;
    logic signed [22:0] a1_reg;
    logic signed [37:0] m2_reg;
    logic signed [24:0] fine_reg;
    logic signed [25:0] v1_reg;
    logic signed [51:0] sq_reg;
    logic signed [41:0] m5_reg, m2b_reg, m5d_reg, m2bd_reg;
    logic signed [63:0] x6_reg, x3_reg, v2_reg;
    logic signed [57:0] v1b_reg;
    logic [63:0]        prod_reg, nsub_reg, num_reg;
    logic signed [30:0] den_reg;
    logic [bsc_pkg::RAW_W-1:0] rp_reg [8];
    logic signed [bsc_pkg::TEMP_W-1:0] temp_reg [6];
    bsc_pkg::div_in_t out_reg;

    logic signed [27:0] tc_full;
    logic signed [19:0] tc;
    logic signed [bsc_pkg::TEMP_W-1:0] tc_sat;
    logic signed [67:0] x6_full, x3_full;
    logic signed [74:0] prod_full;
    logic [20:0]        pp;
    logic               na, nb;

    assign tc_full = 28'(fine_reg) * 28'sd5 + 28'sd128;
    assign tc      = $signed(tc_full[27:8]);

    always_comb begin
        if (tc < 20'(bsc_pkg::TEMP_MIN)) begin
            tc_sat = bsc_pkg::TEMP_MIN;
        end else if (tc > 20'(bsc_pkg::TEMP_MAX)) begin
            tc_sat = bsc_pkg::TEMP_MAX;
        end else begin
            tc_sat = tc[bsc_pkg::TEMP_W-1:0];
        end
    end

    assign x6_full   = sq_reg * cal.p6;
    assign x3_full   = sq_reg * cal.p3;
    assign prod_full = v1b_reg * $signed({1'b0, cal.p1});
    assign pp        = 21'h100000 - {1'b0, rp_reg[7]};
    assign na        = num_reg[63];
    assign nb        = den_reg[30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // temperature
            d1_reg   <= $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
            d2_reg   <= $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, cal.t1});
            m1_reg   <= d1_reg * cal.t2;
            sq2_reg  <= d2_reg * d2_reg;
            a1_reg   <= $signed(m1_reg[33:11]);
            m2_reg   <= $signed(sq2_reg[33:12]) * cal.t3;
            fine_reg <= 25'(a1_reg) + 25'($signed(m2_reg[37:14]));
            v1_reg   <= 26'(fine_reg) - bsc_pkg::FINE_OFS;
            // pressure
            sq_reg   <= v1_reg * v1_reg;
            m5_reg   <= v1_reg * cal.p5;
            m2b_reg  <= v1_reg * cal.p2;
            x6_reg   <= x6_full[63:0];
            x3_reg   <= x3_full[63:0];
            m5d_reg  <= m5_reg;
            m2bd_reg <= m2b_reg;
            v2_reg   <= x6_reg + (64'(m5d_reg) <<< 17) + (64'(cal.p4) <<< 35);
            v1b_reg  <= 58'($signed(x3_reg[63:8])) + (58'(m2bd_reg) <<< 12)
                        + (58'sd1 <<< 47);
            prod_reg <= prod_full[63:0];
            nsub_reg <= {12'd0, pp, 31'd0} - v2_reg;
            num_reg  <= nsub_reg * 64'd3125;
            den_reg  <= $signed(prod_reg[63:33]);
            out_reg.num_mag <= na ? (64'd0 - num_reg) : num_reg;
            out_reg.den_mag <= nb ? (31'd0 - den_reg) : den_reg;
            out_reg.neg     <= na ^ nb;
            out_reg.nz      <= (den_reg != 31'sd0);
            out_reg.temp    <= temp_reg[5];
            rp_reg[0]   <= raw_press;
            temp_reg[0] <= tc_sat;
            for (int k = 1; k < 8; k++) begin
                rp_reg[k] <= rp_reg[k-1];
            end
            for (int k = 1; k < 6; k++) begin
                temp_reg[k] <= temp_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out       = out_reg;

endmodule

`default_nettype wire

[rtl/bsc_div.sv]
// ----------------------------------------------------------------------------
// bsc_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire bsc_pkg::div_in_t  in,
    output logic                   out_valid,
    output bsc_pkg::div_out_t      out
);

    localparam int N  = bsc_pkg::NUM_W;
    localparam int DW = bsc_pkg::DEN_W;

    logic [N-1:0]  vld_reg;
    logic [DW-1:0] rem_reg [N];
    logic [N-1:0]  aq_reg  [N];
    logic [DW-1:0] den_reg [N];
    logic          neg_reg [N];
    logic          nz_reg  [N];
    logic signed [bsc_pkg::TEMP_W-1:0] temp_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [N-1:0]  aq_in;
        logic [DW-1:0] den_in;
        logic          neg_in, nz_in;
        logic signed [bsc_pkg::TEMP_W-1:0] temp_in;
        logic [DW:0]   trial, diff;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign aq_in   = in.num_mag;
            assign den_in  = in.den_mag;
            assign neg_in  = in.neg;
            assign nz_in   = in.nz;
            assign temp_in = in.temp;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign aq_in   = aq_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign nz_in   = nz_reg[i-1];
            assign temp_in = temp_reg[i-1];
        end

        assign trial = {rem_in, aq_in[N-1]};
        assign ge    = (trial >= {1'b0, den_in});
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                aq_reg[i]   <= {aq_in[N-2:0], ge};
                den_reg[i]  <= den_in;
                neg_reg[i]  <= neg_in;
                nz_reg[i]   <= nz_in;
                temp_reg[i] <= temp_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out.quot  = aq_reg[N-1];
    assign out.neg   = neg_reg[N-1];
    assign out.nz    = nz_reg[N-1];
    assign out.temp  = temp_reg[N-1];

endmodule

`default_nettype wire

[rtl/bsc_back.sv]
// ----------------------------------------------------------------------------
// bsc_back
// Pressure refinement terms, final sum and saturation, seven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_back (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire bsc_pkg::div_out_t                    in,
    input  wire bsc_pkg::cal_t                        cal,
    output logic                                      out_valid,
    output logic signed [bsc_pkg::TEMP_W-1:0]         temp_centi,
    output logic [bsc_pkg::PRESS_W-1:0]               press_q24_8,
    output logic                                      press_valid
);

    localparam int NST = 7;

    logic [NST-1:0] vld_reg;
    logic signed [bsc_pkg::TEMP_W-1:0] temp_reg [NST-1];
    logic [NST-2:0] nz_reg;

    logic [63:0]        p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [63:0]        pll_reg, sqp_reg, w2_reg, w2d_reg, w2e_reg, w1f_reg, s_reg;
    logic [30:0]        plh_reg;
    logic signed [48:0] w2l_reg, w1a_reg;
    logic [31:0]        w2h_reg, w1b_reg;
    logic signed [bsc_pkg::TEMP_W-1:0] temp_out_reg;
    logic [bsc_pkg::PRESS_W-1:0]       press_out_reg;
    logic                              pv_out_reg;

    logic [63:0]        ph, hl_full, w2h_full, w1b_full;
    logic [63:0]        r;
    logic [bsc_pkg::PRESS_W-1:0] r_sat;

    assign ph       = 64'($signed(p1_reg[63:13]));
    assign hl_full  = ph[31:0] * ph[63:32];
    assign w2h_full = p1_reg[63:32] * 32'(cal.p8);
    assign w1b_full = sqp_reg[63:32] * 32'(cal.p9);
    assign r        = 64'($signed(s_reg[63:8])) + (64'(cal.p7) <<< 4);

    always_comb begin
        if (r[63]) begin
            r_sat = '0;
        end else if (|r[62:bsc_pkg::PRESS_W]) begin
            r_sat = bsc_pkg::PRESS_MAX;
        end else begin
            r_sat = r[bsc_pkg::PRESS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= in.neg ? (64'd0 - in.quot) : in.quot;
            pll_reg <= ph[31:0] * ph[31:0];
            plh_reg <= hl_full[30:0];
            w2l_reg <= $signed({1'b0, p1_reg[31:0]}) * cal.p8;
            w2h_reg <= w2h_full[31:0];
            p2_reg  <= p1_reg;
            sqp_reg <= pll_reg + {plh_reg, 33'd0};
            w2_reg  <= 64'(w2l_reg) + {w2h_reg, 32'd0};
            p3_reg  <= p2_reg;
            w1a_reg <= $signed({1'b0, sqp_reg[31:0]}) * cal.p9;
            w1b_reg <= w1b_full[31:0];
            w2d_reg <= w2_reg;
            p4_reg  <= p3_reg;
            w1f_reg <= 64'(w1a_reg) + {w1b_reg, 32'd0};
            w2e_reg <= w2d_reg;
            p5_reg  <= p4_reg;
            s_reg   <= p5_reg + 64'($signed(w1f_reg[63:25]))
                       + 64'($signed(w2e_reg[63:19]));
            temp_out_reg  <= temp_reg[NST-2];
            press_out_reg <= nz_reg[NST-2] ? r_sat : '0;
            pv_out_reg    <= nz_reg[NST-2];
            temp_reg[0] <= in.temp;
            nz_reg      <= {nz_reg[NST-3:0], in.nz};
            for (int k = 1; k < NST-1; k++) begin
                temp_reg[k] <= temp_reg[k-1];
            end
        end
    end

    assign out_valid   = vld_reg[NST-1];
    assign temp_centi  = temp_out_reg;
    assign press_q24_8 = press_out_reg;
    assign press_valid = pv_out_reg;

endmodule

`default_nettype wire

[rtl/baro_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Barometric sensor temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// One reading pair is taken every cycle while s_tready is high. Each result
// passes 11 front stages, a 64-stage divider producing one quotient bit per
// stage and 7 back stages. The pipeline advances as a whole whenever the
// output register is empty or being taken, so s_tready falls only while a
// result waits with m_tready low. Calibration registers must be written via
// the cfg port only with no transaction in flight; the block does not check.
`default_nettype none

module baro_sensor_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temp[19:0], raw_press[39:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // temp_centi[14:0], press_q24_8[39:15]
    output logic [0:0]       m_tuser,   // press_valid[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg, cal_press_b_reg;
    logic [15:0] cal_press_c_reg;

    bsc_pkg::cal_t     cal;
    bsc_pkg::div_in_t  div_in;
    bsc_pkg::div_out_t div_out;
    logic              en, front_valid, div_valid;
    logic signed [bsc_pkg::TEMP_W-1:0] temp_centi;
    logic [bsc_pkg::PRESS_W-1:0]       press_q24_8;
    logic                              press_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_press_c_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bsc_pkg::CFG_CAL_TEMP:    cal_temp_reg    <= cfg_data[47:0];
                bsc_pkg::CFG_CAL_PRESS_A: cal_press_a_reg <= cfg_data;
                bsc_pkg::CFG_CAL_PRESS_B: cal_press_b_reg <= cfg_data;
                bsc_pkg::CFG_CAL_PRESS_C: cal_press_c_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cal.t1 = cal_temp_reg[15:0];
    assign cal.t2 = $signed(cal_temp_reg[31:16]);
    assign cal.t3 = $signed(cal_temp_reg[47:32]);
    assign cal.p1 = cal_press_a_reg[15:0];
    assign cal.p2 = $signed(cal_press_a_reg[31:16]);
    assign cal.p3 = $signed(cal_press_a_reg[47:32]);
    assign cal.p4 = $signed(cal_press_a_reg[63:48]);
    assign cal.p5 = $signed(cal_press_b_reg[15:0]);
    assign cal.p6 = $signed(cal_press_b_reg[31:16]);
    assign cal.p7 = $signed(cal_press_b_reg[47:32]);
    assign cal.p8 = $signed(cal_press_b_reg[63:48]);
    assign cal.p9 = $signed(cal_press_c_reg);

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    bsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .raw_temp  (s_tdata[19:0]),
        .raw_press (s_tdata[39:20]),
        .cal       (cal),
        .out_valid (front_valid),
        .out       (div_in)
    );

    bsc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in        (div_in),
        .out_valid (div_valid),
        .out       (div_out)
    );

    bsc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (div_valid),
        .in          (div_out),
        .cal         (cal),
        .out_valid   (m_tvalid),
        .temp_centi  (temp_centi),
        .press_q24_8 (press_q24_8),
        .press_valid (press_valid)
    );

    assign m_tdata = {press_q24_8, temp_centi};
    assign m_tuser = press_valid;

endmodule

`default_nettype wire

[rtl/bsc_checker.sv]
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks for baro_sensor_compensation, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[39:15] == 25'd0)
        else $error("pressure nonzero without valid flag");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[14:0]) >= bsc_pkg::TEMP_MIN
                  && $signed(m_tdata[14:0]) <= bsc_pkg::TEMP_MAX)
        else $error("temperature outside saturation range");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire
